FILE: sv/chance_constrained_polytope_locator_core_macros.svh
// Assertion macros shared by the locator RTL.
// No dependencies; included by the modules that check themselves.
`ifndef CHANCE_CONSTRAINED_POLYTOPE_LOCATOR_CORE_MACROS_SVH
`define CHANCE_CONSTRAINED_POLYTOPE_LOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CCPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccpl check failed");

// Next-cycle implication, disabled during reset
`define CCPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccpl check failed");

`endif

FILE: sv/ccpl_pkg.sv
// Shared types and constants for the polytope locator.
// No dependencies.
package ccpl_pkg;

  localparam int MAX_REGIONS_DEF      = 16;
  localparam int FACES_PER_REGION_DEF = 6;

  localparam int NRM_W  = 16;
  localparam int OFF_W  = 32;
  localparam int POS_W  = 32;
  localparam int VAR_W  = 32;
  localparam int IDX_W  = 7;
  localparam int RGN_W  = 5;
  localparam int K_W    = 16;
  localparam int FACE_W = 3 * NRM_W + OFF_W;
  localparam int ADDR_W = 3;

  localparam logic REG_REGIONS = 1'b0;
  localparam logic REG_MARGIN  = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic load;   // capture belief
    logic wr_en;  // table write
    logic issue;  // face read issued
    logic last;   // issued face is the region's last
  } cmd_t;

  typedef struct packed {
    logic res_valid;
    logic pass;
    logic last;
  } sts_t;

endpackage

FILE: sv/ccpl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ccpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ccpl_dp.sv
// Datapath: face table and the pipelined chance-constraint test per face.
// Depends on ccpl_pkg and ccpl_ram.
module ccpl_dp
  import ccpl_pkg::*;
#(
  parameter int DEPTH = MAX_REGIONS_DEF * FACES_PER_REGION_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic [AW-1:0]           wr_addr,
  input  logic [AW-1:0]           rd_addr,
  input  logic signed [NRM_W-1:0] normal_x,
  input  logic signed [NRM_W-1:0] normal_y,
  input  logic signed [NRM_W-1:0] normal_z,
  input  logic signed [OFF_W-1:0] offset,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [VAR_W-1:0]        var_x,
  input  logic [VAR_W-1:0]        var_y,
  input  logic [VAR_W-1:0]        var_z,
  input  logic [K_W-1:0]          margin,
  output sts_t                    sts
);

  logic [FACE_W-1:0] rd_data;

  ccpl_ram #(.WIDTH(FACE_W), .DEPTH(DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data ({normal_x, normal_y, normal_z, offset}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // belief held for the whole query
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic [VAR_W-1:0]        vx_r, vy_r, vz_r;
  logic [2*K_W-1:0]        k2_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= pos_x;
      py_r <= pos_y;
      pz_r <= pos_z;
      vx_r <= var_x;
      vy_r <= var_y;
      vz_r <= var_z;
    end
    k2_r <= margin * margin;
  end

  // stage valid / last-face tags, one per pipeline step
  logic [6:0] v_r, l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      l_r <= '0;
    end else begin
      v_r <= {v_r[5:0], cmd.issue};
      l_r <= {l_r[5:0], cmd.last};
    end
  end

  // stage 2: normal times mean, normal squared
  logic signed [NRM_W-1:0] ax, ay, az;
  logic signed [OFF_W-1:0] bo;
  assign {ax, ay, az, bo} = rd_data;

  logic signed [NRM_W+POS_W-1:0] pax_r, pay_r, paz_r;
  logic [2*NRM_W-1:0]            aax_r, aay_r, aaz_r;
  logic signed [OFF_W-1:0]       b2_r;
  logic signed [2*NRM_W-1:0]     aax_s, aay_s, aaz_s;

  assign aax_s = ax * ax;
  assign aay_s = ay * ay;
  assign aaz_s = az * az;

  always_ff @(posedge clk) begin
    pax_r <= ax * px_r;
    pay_r <= ay * py_r;
    paz_r <= az * pz_r;
    aax_r <= aax_s;
    aay_r <= aay_s;
    aaz_r <= aaz_s;
    b2_r  <= bo;
  end

  // stage 3: slack in Q.30, weighted variances
  localparam int SL_W = 52;
  localparam int PA_W = NRM_W + POS_W;

  logic signed [SL_W-1:0] slack_r, slack_nxt;
  logic [63:0]            wx_r, wy_r, wz_r;

  assign slack_nxt = $signed({{(SL_W-OFF_W-14){b2_r[OFF_W-1]}}, b2_r, 14'b0})
                   - $signed({{(SL_W-PA_W){pax_r[PA_W-1]}}, pax_r})
                   - $signed({{(SL_W-PA_W){pay_r[PA_W-1]}}, pay_r})
                   - $signed({{(SL_W-PA_W){paz_r[PA_W-1]}}, paz_r});

  always_ff @(posedge clk) begin
    slack_r <= slack_nxt;
    wx_r    <= aax_r * vx_r;
    wy_r    <= aay_r * vy_r;
    wz_r    <= aaz_r * vz_r;
  end

  // stage 4: sign split, variance sum
  logic        neg4_r;
  logic [50:0] sa_r;
  logic [63:0] vs_r;

  always_ff @(posedge clk) begin
    neg4_r <= slack_r[SL_W-1];
    sa_r   <= slack_r[50:0];
    vs_r   <= wx_r + wy_r + wz_r;
  end

  // stage 5: partial products of s*s and k2*V
  logic        neg5_r;
  logic [37:0] p_hh_r;
  logic [50:0] p_hl_r;
  logic [63:0] p_ll_r, r_h_r, r_l_r;

  always_ff @(posedge clk) begin
    neg5_r <= neg4_r;
    p_hh_r <= sa_r[50:32] * sa_r[50:32];
    p_hl_r <= sa_r[50:32] * sa_r[31:0];
    p_ll_r <= sa_r[31:0] * sa_r[31:0];
    r_h_r  <= k2_r * vs_r[63:32];
    r_l_r  <= k2_r * vs_r[31:0];
  end

  // stage 6: both sides in Q.68
  logic        neg6_r;
  logic [111:0] lhs_r, lhs_nxt;
  logic [95:0]  rhs_r, rhs_nxt;

  assign lhs_nxt = {2'b0, p_hh_r, 72'b0} + {20'b0, p_hl_r, 41'b0} + {40'b0, p_ll_r, 8'b0};
  assign rhs_nxt = {r_h_r, 32'b0} + {32'b0, r_l_r};

  always_ff @(posedge clk) begin
    neg6_r <= neg5_r;
    lhs_r  <= lhs_nxt;
    rhs_r  <= rhs_nxt;
  end

  // stage 7: decision
  logic pass_r;

  always_ff @(posedge clk) begin
    pass_r <= !neg6_r && (lhs_r >= {16'b0, rhs_r});
  end

  assign sts.res_valid = v_r[6];
  assign sts.last      = l_r[6];
  assign sts.pass      = pass_r;

endmodule

FILE: sv/ccpl_ctrl.sv
// Controller: handshakes, face read sequencing and region result tracking.
// Depends on ccpl_pkg and the macros header.
`include "chance_constrained_polytope_locator_core_macros.svh"

module ccpl_ctrl
  import ccpl_pkg::*;
#(
  parameter int MAX_REGIONS      = MAX_REGIONS_DEF,
  parameter int FACES_PER_REGION = FACES_PER_REGION_DEF,
  parameter int DEPTH            = MAX_REGIONS * FACES_PER_REGION,
  parameter int AW               = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_mode,
  input  logic [IDX_W-1:0] in_entry_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [RGN_W-1:0] out_region_found,
  input  logic [RGN_W-1:0] regions_in_use,
  output cmd_t             cmd,
  output logic [AW-1:0]    wr_addr,
  output logic [AW-1:0]    rd_addr,
  input  sts_t             sts
);

  localparam int RGW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int FW  = (FACES_PER_REGION > 1) ? $clog2(FACES_PER_REGION) : 1;
  localparam logic [FW-1:0] FACE_LAST = FW'(FACES_PER_REGION - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [FW-1:0]  face_r, face_nxt;
  logic [RGW-1:0] rgn_iss_r, rgn_iss_nxt;
  logic [RGW-1:0] rgn_ret_r, rgn_ret_nxt;
  logic [RGW-1:0] rgn_last_r, rgn_last_nxt;
  logic           ok_r, ok_nxt;
  logic           hit_r, hit_nxt;
  logic [RGW:0]   found_r, found_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [RGN_W-1:0] out_rgn_r, out_rgn_nxt;

  logic        accept, query, in_range, ok_now, iss_last;
  logic [31:0] n_eff, n_m1;
  logic [RGW+RGN_W:0] found_ext;

  assign accept   = in_valid && !in_stall;
  assign query    = accept && (in_mode == MODE_QUERY);
  assign in_range = ({25'b0, in_entry_index} < DEPTH);
  assign in_stall = (state_r != ST_IDLE);

  assign n_eff = ({27'b0, regions_in_use} > MAX_REGIONS) ? MAX_REGIONS
                                                         : {27'b0, regions_in_use};
  assign n_m1  = n_eff - 32'd1;

  logic [AW+IDX_W-1:0] idx_ext;
  assign idx_ext = {{AW{1'b0}}, in_entry_index};

  assign wr_addr   = idx_ext[AW-1:0];
  assign rd_addr   = addr_r;
  assign iss_last  = (face_r == FACE_LAST);

  assign cmd.load  = query;
  assign cmd.wr_en = accept && (in_mode == MODE_WRITE) && in_range;
  assign cmd.issue = (state_r == ST_SCAN);
  assign cmd.last  = (state_r == ST_SCAN) && iss_last;

  assign ok_now    = ok_r && sts.pass;
  assign found_ext = {{RGN_W{1'b0}}, found_r};

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    face_nxt      = face_r;
    rgn_iss_nxt   = rgn_iss_r;
    rgn_ret_nxt   = rgn_ret_r;
    rgn_last_nxt  = rgn_last_r;
    ok_nxt        = ok_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rgn_nxt   = out_rgn_r;

    if (sts.res_valid) begin
      if (sts.last) begin
        ok_nxt      = 1'b1;
        rgn_ret_nxt = rgn_ret_r + 1'b1;
        if (ok_now && !hit_r) begin
          hit_nxt   = 1'b1;
          found_nxt = {1'b0, rgn_ret_r} + 1'b1;
        end
      end else begin
        ok_nxt = ok_now;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (query) begin
          addr_nxt     = '0;
          face_nxt     = '0;
          rgn_iss_nxt  = '0;
          rgn_ret_nxt  = '0;
          rgn_last_nxt = n_m1[RGW-1:0];
          ok_nxt       = 1'b1;
          hit_nxt      = 1'b0;
          found_nxt    = '0;
          state_nxt    = (n_eff == 32'd0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (iss_last) begin
          face_nxt    = '0;
          rgn_iss_nxt = rgn_iss_r + 1'b1;
          if (rgn_iss_r == rgn_last_r) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          face_nxt = face_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (sts.res_valid && sts.last && (rgn_ret_r == rgn_last_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_rgn_nxt   = hit_r ? found_ext[RGN_W-1:0] : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b1;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    face_r     <= face_nxt;
    rgn_iss_r  <= rgn_iss_nxt;
    rgn_ret_r  <= rgn_ret_nxt;
    rgn_last_r <= rgn_last_nxt;
    found_r    <= found_nxt;
    out_rgn_r  <= out_rgn_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_region_found = out_rgn_r;

  // results only come back for a query in flight
  `CCPL_ASSERT_NOW(a_res_in_query, clk, rst_n, sts.res_valid, state_r != ST_IDLE)
  // no face read outside the scan
  `CCPL_ASSERT_NOW(a_issue_scan, clk, rst_n, cmd.issue, state_r == ST_SCAN)
  // leaving DONE always presents a result
  `CCPL_ASSERT_NEXT(a_done_out, clk, rst_n,
                    (state_r == ST_DONE) && !(out_valid_r && out_stall), out_valid_r)

endmodule

FILE: sv/chance_constrained_polytope_locator_core.sv
// Top level of the Gaussian chance-constraint polytope locator.
// Depends on ccpl_pkg, ccpl_ctrl, ccpl_dp (and ccpl_ram below it).
//
//   port group  direction  handshake           payload
//   in_*        input      in_valid/in_stall   mode, entry index, face, belief
//   out_*       output     out_valid/out_stall region_found
//   APB         input      psel/penable        regions_in_use, margin_factor
//
// A query reads the face table one face a cycle through a seven-stage test
// pipeline. rst_n is synchronous; the table is not cleared. A stalled result
// holds the next query in its last state.
module chance_constrained_polytope_locator_core
  import ccpl_pkg::*;
#(
  parameter int MAX_REGIONS      = MAX_REGIONS_DEF,
  parameter int FACES_PER_REGION = FACES_PER_REGION_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic signed [NRM_W-1:0] in_normal_x,
  input  logic signed [NRM_W-1:0] in_normal_y,
  input  logic signed [NRM_W-1:0] in_normal_z,
  input  logic signed [OFF_W-1:0] in_offset,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [VAR_W-1:0]        in_var_x,
  input  logic [VAR_W-1:0]        in_var_y,
  input  logic [VAR_W-1:0]        in_var_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RGN_W-1:0]        out_region_found,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DEPTH = MAX_REGIONS * FACES_PER_REGION;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [RGN_W-1:0] regions_r;
  logic [K_W-1:0]   margin_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regions_r <= '0;
      margin_r  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_REGIONS) begin
        regions_r <= pwdata[RGN_W-1:0];
      end else begin
        margin_r <= pwdata[K_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MARGIN) ? {16'b0, margin_r} : {27'b0, regions_r};

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] wr_addr, rd_addr;

  ccpl_ctrl #(
    .MAX_REGIONS      (MAX_REGIONS),
    .FACES_PER_REGION (FACES_PER_REGION),
    .DEPTH            (DEPTH),
    .AW               (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_region_found (out_region_found),
    .regions_in_use   (regions_r),
    .cmd              (cmd),
    .wr_addr          (wr_addr),
    .rd_addr          (rd_addr),
    .sts              (sts)
  );

  ccpl_dp #(.DEPTH(DEPTH), .AW(AW)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .normal_x (in_normal_x),
    .normal_y (in_normal_y),
    .normal_z (in_normal_z),
    .offset   (in_offset),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .var_x    (in_var_x),
    .var_y    (in_var_y),
    .var_z    (in_var_z),
    .margin   (margin_r),
    .sts      (sts)
  );

endmodule
